// ----- rtl/a85_pkg.sv -----
// Shared types and constants of the Ascii85 decoder.
// Used by a85_front, a85_fifo, a85_back and ascii85_decoder.
`default_nettype none

package a85_pkg;

  // Result kinds on the output channel.
  typedef enum logic [1:0] {
    KindData = 2'd0,
    KindEnd  = 2'd1,
    KindErr  = 2'd2
  } a85_kind_e;

  // Character codes that steer the decoding.
  localparam logic [7:0] CharFirstDigit = 8'h21;  // '!'
  localparam logic [7:0] CharLastDigit  = 8'h75;  // 'u'
  localparam logic [7:0] CharZero       = 8'h7A;  // 'z'
  localparam logic [7:0] CharSpace      = 8'h20;
  localparam logic [7:0] CharLf         = 8'h0A;
  localparam logic [7:0] CharCr         = 8'h0D;
  localparam logic [7:0] CharTab        = 8'h09;

  localparam logic [31:0] Base85   = 32'd85;
  localparam logic [2:0]  GroupLen = 3'd5;

  // One work item for the back end: up to four data bytes taken from the top
  // of the word (after padding), then an error result, then an end marker.
  typedef struct packed {
    logic [31:0] word;    // group value before padding
    logic [2:0]  pad;     // number of 'u' digits to append (0..4)
    logic [2:0]  nbytes;  // data bytes to emit (0..4)
    logic        err;     // emit an invalid character result
    logic        fin;     // emit an end of message marker
  } a85_cmd_t;

  // Powers of 85 used to pad a partial group in one multiplication.
  function automatic logic [31:0] a85_pow85(input logic [2:0] k);
    logic [31:0] p;
    case (k)
      3'd1:    p = 32'd85;
      3'd2:    p = 32'd7225;
      3'd3:    p = 32'd614125;
      3'd4:    p = 32'd52200625;
      default: p = 32'd1;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/ascii85_decoder.sv -----
// Top level of the streaming Ascii85 decoder.
// Instantiates a85_front, a85_fifo and a85_back; depends on a85_pkg.
//
// The decoder takes one character per cycle and gives one result item per
// cycle while the receiver is ready. The front end classifies each character
// and updates the group in the same cycle, so input is accepted every cycle
// while the command queue (QueueDepth entries) has room. The back end expands
// each command into one to five results, one per cycle while the output is
// taken. A run of complete groups (four bytes per five characters) fits that
// rate, but a run of 'z' characters (four bytes per character) is limited by
// the single output port, and input stalls once the queue fills. With the
// queue and the expander idle, the queue is written at the edge that accepts
// a character, its padded command then loads the expander, and its first
// result is loaded into the output register after that.
`default_nettype none

module ascii85_decoder
  import a85_pkg::*;
#(
  parameter int unsigned QueueDepth = 4
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] char_code_i,
  input  wire logic       message_end_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic [1:0]      kind_o,
  output logic            run_last_o
);

  logic     q_full, q_push, q_valid, q_pop;
  a85_cmd_t q_push_cmd, q_head;

  // Character classification and group accumulation.
  a85_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .char_code_i   (char_code_i),
    .message_end_i (message_end_i),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_cmd_o       (q_push_cmd)
  );

  // Command queue that decouples the two ends.
  a85_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (q_push_cmd),
    .full_o     (q_full),
    .valid_o    (q_valid),
    .head_o     (q_head),
    .pop_i      (q_pop)
  );

  // Result expansion and output register.
  a85_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_cmd_i     (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .kind_o      (kind_o),
    .run_last_o  (run_last_o)
  );

endmodule

`default_nettype wire

// ----- rtl/a85_front.sv -----
// Front end of the Ascii85 decoder: accepts characters, keeps the group state
// and pushes one command per item that causes results. Depends on a85_pkg.
`default_nettype none

module a85_front
  import a85_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] char_code_i,
  input  wire logic       message_end_i,
  input  wire logic       q_full_i,
  output logic            q_push_o,
  output a85_cmd_t        q_cmd_o
);

  logic [31:0] group_q, group_d;
  logic [2:0]  cnt_q, cnt_d;
  logic        disc_q, disc_d;

  logic        is_space, is_digit, primary, accept;
  logic [6:0]  digit;
  logic [31:0] acc;

  // Classify the character and form the next accumulated group value.
  assign is_space = (char_code_i == CharSpace) || (char_code_i == CharLf) ||
                    (char_code_i == CharCr) || (char_code_i == CharTab);
  assign is_digit = (char_code_i >= CharFirstDigit) && (char_code_i <= CharLastDigit);
  assign digit    = 7'(char_code_i - CharFirstDigit);
  assign acc      = 32'(group_q * Base85) + {25'd0, digit};

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // Decide the command and the next state for the offered item.
  always_comb begin
    group_d = group_q;
    cnt_d   = cnt_q;
    disc_d  = disc_q;
    primary = 1'b0;
    q_cmd_o = '0;
    if (!disc_q) begin
      if (char_code_i == CharZero && cnt_q == 3'd0) begin
        primary        = 1'b1;
        q_cmd_o.nbytes = 3'd4;
      end else if (is_digit) begin
        if (cnt_q == GroupLen - 3'd1) begin
          primary        = 1'b1;
          q_cmd_o.word   = acc;
          q_cmd_o.nbytes = 3'd4;
          group_d        = '0;
          cnt_d          = '0;
        end else begin
          group_d = acc;
          cnt_d   = cnt_q + 3'd1;
        end
      end else if (!is_space) begin
        primary     = 1'b1;
        q_cmd_o.err = 1'b1;
        disc_d      = 1'b1;
      end
    end
    q_cmd_o.fin = message_end_i;
    if (message_end_i) begin
      // A partial group is flushed only when no error is pending.
      if (!disc_d && cnt_d != 3'd0) begin
        q_cmd_o.word   = group_d;
        q_cmd_o.pad    = GroupLen - cnt_d;
        q_cmd_o.nbytes = cnt_d - 3'd1;
      end
      group_d = '0;
      cnt_d   = '0;
      disc_d  = 1'b0;
    end
  end

  assign q_push_o = accept && (primary || message_end_i);

  // Group state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_q <= '0;
      cnt_q   <= '0;
      disc_q  <= 1'b0;
    end else if (accept) begin
      group_q <= group_d;
      cnt_q   <= cnt_d;
      disc_q  <= disc_d;
    end
  end

  // The digit count never reaches a full group between items.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q < GroupLen)
    else $error("a85_front: digit count out of range");

  // A message end always pushes a command carrying the end marker.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && message_end_i) |-> (q_push_o && q_cmd_o.fin))
    else $error("a85_front: message end without end marker");

endmodule

`default_nettype wire

// ----- rtl/a85_fifo.sv -----
// Short command queue between the front and back ends of the decoder.
// Depends on a85_pkg for the command type.
`default_nettype none

module a85_fifo
  import a85_pkg::*;
#(
  parameter int unsigned Depth = 4
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire a85_cmd_t push_cmd_i,
  output logic          full_o,
  output logic          valid_o,
  output a85_cmd_t      head_o,
  input  wire logic     pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  a85_cmd_t          mem_q [Depth];
  logic [PtrW-1:0]   wr_q, rd_q;
  logic [CntW-1:0]   cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_cmd_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("a85_fifo: push into a full queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> valid_o)
    else $error("a85_fifo: pop from an empty queue");

endmodule

`default_nettype wire

// ----- rtl/a85_back.sv -----
// Back end of the Ascii85 decoder: pads a partial group, then expands each
// command into results, one per cycle while output is taken. Depends on a85_pkg.
`default_nettype none

module a85_back
  import a85_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     q_valid_i,
  input  wire a85_cmd_t q_cmd_i,
  output logic          q_pop_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output logic [7:0]    out_byte_o,
  output logic [1:0]    kind_o,
  output logic          run_last_o
);

  // Expander registers: the command now being turned into results.
  logic        exp_valid_q, exp_valid_d;
  logic [31:0] word_q, word_d;
  logic [2:0]  nbytes_q, nbytes_d;
  logic        err_q, err_d;
  logic        fin_q, fin_d;

  // Output register.
  logic        out_valid_q, out_valid_d;
  logic [7:0]  byte_q;
  a85_kind_e   kind_q;
  logic        last_q;

  logic [31:0] pow;
  logic [31:0] padded;
  logic [7:0]  cur_byte;
  a85_kind_e   cur_kind;
  logic        cur_last, issue, load;

  // Padding with k digits of 84 equals v * 85^k + 85^k - 1 modulo 2^32.
  assign pow    = a85_pow85(q_cmd_i.pad);
  assign padded = 32'(q_cmd_i.word * pow) + (pow - 32'd1);

  // Result that the expander offers this cycle.
  always_comb begin
    if (nbytes_q != 3'd0) begin
      cur_byte = word_q[31:24];
      cur_kind = KindData;
      cur_last = (nbytes_q == 3'd1) && !err_q && !fin_q;
    end else if (err_q) begin
      cur_byte = 8'd0;
      cur_kind = KindErr;
      cur_last = !fin_q;
    end else begin
      cur_byte = 8'd0;
      cur_kind = KindEnd;
      cur_last = 1'b1;
    end
  end

  assign issue   = exp_valid_q && (!out_valid_q || out_ready_i);
  assign load    = q_valid_i && (!exp_valid_q || (issue && cur_last));
  assign q_pop_o = load;

  // Expander next state.
  always_comb begin
    exp_valid_d = exp_valid_q;
    word_d      = word_q;
    nbytes_d    = nbytes_q;
    err_d       = err_q;
    fin_d       = fin_q;
    if (load) begin
      exp_valid_d = 1'b1;
      word_d      = padded;
      nbytes_d    = q_cmd_i.nbytes;
      err_d       = q_cmd_i.err;
      fin_d       = q_cmd_i.fin;
    end else if (issue && cur_last) begin
      exp_valid_d = 1'b0;
    end else if (issue) begin
      if (nbytes_q != 3'd0) begin
        word_d   = {word_q[23:0], 8'd0};
        nbytes_d = nbytes_q - 3'd1;
      end else begin
        err_d = 1'b0;
      end
    end
  end

  // Output register next valid.
  always_comb begin
    if (issue) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      exp_valid_q <= exp_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q   <= word_d;
    nbytes_q <= nbytes_d;
    err_q    <= err_d;
    fin_q    <= fin_d;
    if (issue) begin
      byte_q <= cur_byte;
      kind_q <= cur_kind;
      last_q <= cur_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = byte_q;
  assign kind_o      = kind_q;
  assign run_last_o  = last_q;

  // A live command always has at least one result left to give.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    exp_valid_q |-> (nbytes_q != 3'd0 || err_q || fin_q))
    else $error("a85_back: empty command in expander");

  // The end marker is always the last result of its item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && kind_q == KindEnd) |-> last_q)
    else $error("a85_back: end marker not last");

endmodule

`default_nettype wire

// ----- sim/a85_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard for the Ascii85 decoder: watches the character and result channels,
// predicts the result items of each accepted character and compares them in order.
// Depends on a85_pkg for the result kinds and the character codes.

module a85_checker
  import a85_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [7:0] char_code_i,
  input  logic       message_end_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic [7:0] out_byte_i,
  input  logic [1:0] kind_i,
  input  logic       run_last_i,
  output int         mismatches_o,
  output int         awaited_o,
  output int         chars_o,
  output int         results_o,
  output int         errors_o
);

  // Value of the 'u' digit that pads a partial group.
  localparam logic [31:0] PadDigit = 32'd84;
  localparam int          MaxReports = 10;

  typedef struct packed {
    logic [7:0] data;
    a85_kind_e  kind;
    logic       last;
  } a85_result_t;

  // Results still owed by the decoder, oldest first.
  a85_result_t awaited_q[$];

  // Decoding state of the current message.
  logic [31:0] group_acc;
  logic [2:0]  digits_held;
  logic        skipping;

  int mismatches;
  int chars_seen;
  int results_seen;
  int errors_seen;

  function automatic bit is_blank(input logic [7:0] c);
    return c == CharSpace || c == CharLf || c == CharCr || c == CharTab;
  endfunction

  function automatic void push_result(input logic [7:0] d, input a85_kind_e k);
    a85_result_t r;
    r.data = d;
    r.kind = k;
    r.last = 1'b0;
    awaited_q.insert(awaited_q.size(), r);
  endfunction

  // Work out the results that one character causes and queue them.
  function automatic void decode_char(input logic [7:0] c, input logic fin);
    int unsigned first;
    logic [31:0] padded;
    first = awaited_q.size();
    if (!skipping) begin
      if (is_blank(c)) begin
        // Whitespace carries no digit and leaves the group alone.
      end else if (c == CharZero && digits_held == 3'd0) begin
        repeat (4) push_result(8'h00, KindData);
      end else if (c >= CharFirstDigit && c <= CharLastDigit) begin
        group_acc = group_acc * Base85 + 32'(c - CharFirstDigit);
        digits_held = digits_held + 3'd1;
        if (digits_held == GroupLen) begin
          for (int i = 3; i >= 0; i--) push_result(group_acc[8*i +: 8], KindData);
          group_acc = '0;
          digits_held = 3'd0;
        end
      end else begin
        push_result(8'h00, KindErr);
        skipping = 1'b1;
      end
    end

    // At the message end a partial group is padded with 'u' digits and
    // flushed, unless the message already failed.
    if (fin) begin
      if (!skipping && digits_held != 3'd0) begin
        padded = group_acc;
        repeat (int'(GroupLen - digits_held)) padded = padded * Base85 + PadDigit;
        for (int i = 3; i >= int'(GroupLen - digits_held); i--) begin
          push_result(padded[8*i +: 8], KindData);
        end
      end
      push_result(8'h00, KindEnd);
      group_acc = '0;
      digits_held = 3'd0;
      skipping = 1'b0;
    end

    if (awaited_q.size() > first) awaited_q[awaited_q.size() - 1].last = 1'b1;
  endfunction

  // Results are checked before the character of the same edge is predicted;
  // the decoder cannot answer a character in the cycle it takes it.
  always @(posedge clk_i or negedge rst_ni) begin
    a85_result_t exp_r;
    if (!rst_ni) begin
      awaited_q.delete();
      group_acc = '0;
      digits_held = 3'd0;
      skipping = 1'b0;
      mismatches = 0;
      chars_seen = 0;
      results_seen = 0;
      errors_seen = 0;
      mismatches_o <= 0;
      awaited_o <= 0;
      chars_o <= 0;
      results_o <= 0;
      errors_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        results_seen++;
        if (kind_i == KindErr) errors_seen++;
        if (awaited_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxReports) begin
            $display("%0t: result item with none owed: byte %02h kind %0d last %0b",
                     $time, out_byte_i, kind_i, run_last_i);
          end
        end else begin
          exp_r = awaited_q.pop_front();
          if (out_byte_i !== exp_r.data || kind_i !== exp_r.kind ||
              run_last_i !== exp_r.last) begin
            mismatches++;
            if (mismatches <= MaxReports) begin
              $write("%0t: result mismatch: expected byte %02h kind %0d last %0b, ",
                     $time, exp_r.data, exp_r.kind, exp_r.last);
              $display("got byte %02h kind %0d last %0b",
                       out_byte_i, kind_i, run_last_i);
            end
          end
        end
      end

      if (in_valid_i && in_ready_i) begin
        chars_seen++;
        decode_char(char_code_i, message_end_i);
      end

      mismatches_o <= mismatches;
      awaited_o <= awaited_q.size();
      chars_o <= chars_seen;
      results_o <= results_seen;
      errors_o <= errors_seen;
    end
  end

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
// Top of the Ascii85 decoder testbench: clock, reset, character stimulus and
// result back-pressure. Depends on a85_pkg, ascii85_decoder and a85_checker.

module tb;
  import a85_pkg::*;

  localparam int CycleLimit = 300000;
  localparam int HoldCycles = 150;
  localparam int PhaseChars = 35;

  logic       clk_i;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic [7:0] char_code_i = 8'h00;
  logic       message_end_i = 1'b0;
  logic       out_ready_i = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [7:0] out_byte_o;
  logic [1:0] kind_o;
  logic       run_last_o;

  int mismatches;
  int awaited;
  int chars_taken;
  int results_taken;
  int errors_taken;

  int gap_pct = 0;
  int stall_pct = 0;
  int hold_asked = 0;
  int hold_given = 0;
  int hold_left = 0;
  int cycle_count = 0;
  int random_chars = 0;

  ascii85_decoder uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .char_code_i   (char_code_i),
    .message_end_i (message_end_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .kind_o        (kind_o),
    .run_last_o    (run_last_o)
  );

  a85_checker chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .char_code_i   (char_code_i),
    .message_end_i (message_end_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_i    (out_byte_o),
    .kind_i        (kind_o),
    .run_last_i    (run_last_o),
    .mismatches_o  (mismatches),
    .awaited_o     (awaited),
    .chars_o       (chars_taken),
    .results_o     (results_taken),
    .errors_o      (errors_taken)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Receiver: a requested hold-off keeps ready low until the hold-off count runs
  // out, otherwise ready drops at random per the stall rate.
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_asked != hold_given) begin
      out_ready_i <= 1'b0;
      hold_left <= HoldCycles;
      hold_given <= hold_asked;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Timeout after %0d cycles, %0d result items still owed", cycle_count, awaited);
      $display("** ascii85_decoder: FAILED **");
      $finish;
    end
  end

  function automatic logic [7:0] pick_digit();
    case ($urandom_range(7))
      0:       return CharFirstDigit;
      1:       return CharLastDigit;
      default: return 8'($urandom_range(CharFirstDigit, CharLastDigit));
    endcase
  endfunction

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(3))
      0:       return CharSpace;
      1:       return CharLf;
      2:       return CharCr;
      default: return CharTab;
    endcase
  endfunction

  task automatic set_idling(input int sender_pct, input int receiver_pct);
    gap_pct = sender_pct;
    stall_pct <= receiver_pct;
  endtask

  // Offer one item and return at the edge that accepts it, with valid
  // still high so that the next item can follow without a gap.
  task automatic send_char(input logic [7:0] c, input logic fin);
    if ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < gap_pct);
    end
    in_valid_i <= 1'b1;
    char_code_i <= c;
    message_end_i <= fin;
    @(negedge clk_i);
    while (!in_ready_o) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic send_text(input string s, input logic fin);
    for (int k = 0; k < s.len(); k++) send_char(s[k], fin && k == s.len() - 1);
  endtask

  task automatic drop_valid();
    in_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk_i); while (awaited != 0);
    @(posedge clk_i);
  endtask

  // One random message: mostly whole groups and 'z' with a partial tail,
  // sometimes a corrupted character, a stray 'z' or plain noise.
  task automatic send_message();
    logic [7:0] text_q[$];
    int noise;
    int spot;
    int useful;
    repeat ($urandom_range(0, 3)) begin
      if ($urandom_range(7) == 0) text_q.insert(text_q.size(), CharZero);
      else repeat (5) text_q.insert(text_q.size(), pick_digit());
    end
    repeat ($urandom_range(0, 4)) text_q.insert(text_q.size(), pick_digit());
    noise = $urandom_range(9);
    if (noise == 1) begin
      text_q.insert($urandom_range(0, text_q.size()), CharZero);
    end else if (noise == 2) begin
      text_q.delete();
      repeat ($urandom_range(1, 6)) text_q.insert(text_q.size(), 8'($urandom_range(0, 255)));
    end
    if (text_q.size() == 0) text_q.insert(0, pick_blank());
    useful = text_q.size();
    if (noise == 0) begin
      spot = $urandom_range(0, text_q.size() - 1);
      text_q[spot] = 8'($urandom_range(0, 255));
      useful = spot + 1;
    end
    foreach (text_q[k]) begin
      if ($urandom_range(9) == 0) send_char(pick_blank(), 1'b0);
      send_char(text_q[k], k == text_q.size() - 1);
    end
    random_chars += useful;
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed messages: the corner cases of the format.
    send_char(CharZero, 1'b1);            // 'z' alone as a whole message
    send_text("uuuuu", 1'b0);             // group value wraps past 2^32
    send_char(CharLf, 1'b1);              // whitespace as the last item
    send_char(CharFirstDigit, 1'b1);      // one trailing digit gives no bytes
    send_text("!zA", 1'b1);               // 'z' inside a group, then discarding
    send_char(8'hFF, 1'b1);               // error on the last item
    send_char(CharCr, 1'b0);
    send_char(8'h00, 1'b0);               // error mid-message
    send_char(CharTab, 1'b1);
    send_text("9jqo", 1'b1);              // four digits flush three bytes
    send_text("s8W-!", 1'b0);             // all-ones group
    send_char(CharZero, 1'b1);            // 'z' at a boundary on the last item

    // Long output hold-off while a burst of 'z' fills the decoder.
    hold_asked <= hold_asked + 1;
    for (int k = 0; k < 30; k++) send_char(CharZero, k == 29);
    drop_valid();
    wait_drained();

    // Random messages under each idling mix.
    for (int p = 0; p < 4; p++) begin
      case (p)
        0:       set_idling(0, 0);
        1:       set_idling(79, 0);
        2:       set_idling(0, 79);
        default: set_idling(9, 9);
      endcase
      while (random_chars < (p + 1) * PhaseChars) send_message();
      drop_valid();
      wait_drained();
    end

    set_idling(0, 0);
    repeat (10) @(posedge clk_i);

    $display("Decoded %0d characters into %0d result items, %0d of them errors.",
             chars_taken, results_taken, errors_taken);
    $display("Idle mixes: none, sender 79%%, receiver 79%%, both 9%%; plus a %0d-cycle hold-off.",
             HoldCycles);
    if (mismatches == 0 && awaited == 0) begin
      $display("** ascii85_decoder: PASSED **");
    end else begin
      $display("** ascii85_decoder: FAILED **");
    end
    $finish;
  end

endmodule

// ----- ascii85_decoder.f -----
rtl/a85_pkg.sv
rtl/a85_front.sv
rtl/a85_fifo.sv
rtl/a85_back.sv
rtl/ascii85_decoder.sv
sim/a85_checker.sv
sim/tb.sv
